// File: hw/rtl/tsf_pkg.sv
// Shared constants, register indexes, operation codes and stage types of the touch filter.
package tsf_pkg;

  // Fixed field widths.
  localparam int ADC_BITS   = 12;
  localparam int COORD_W    = 16;
  localparam int SCALE_W    = 20;
  localparam int OFFSET_W   = 16;
  localparam int WIN_W      = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 72;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_X_SCALE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_SCALE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_X_OFFSET = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_OFFSET = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW   = 3'd4;

  // Operation that a word carries down the pipeline.
  localparam logic [1:0] OP_NONE  = 2'd0;  // only a click clear
  localparam logic [1:0] OP_PENUP = 2'd1;  // pen-up scan
  localparam logic [1:0] OP_FINAL = 2'd2;  // last sample of a pen-down scan

  localparam logic [COORD_W-1:0] IDLE_COORD = 16'hFFFF;

  // Register reset values.
  localparam logic signed [SCALE_W-1:0]  SCALE_RESET  = 20'sd65536;
  localparam logic signed [OFFSET_W-1:0] OFFSET_RESET = 16'sd0;
  localparam logic [WIN_W-1:0]           WINDOW_RESET = 12'd50;

  typedef struct packed {
    logic [1:0] op;
    logic       clear;
    logic       raw;
  } ctl_t;

  typedef struct packed {
    logic signed [SCALE_W-1:0]  x_scale;
    logic signed [SCALE_W-1:0]  y_scale;
    logic signed [OFFSET_W-1:0] x_offset;
    logic signed [OFFSET_W-1:0] y_offset;
    logic [WIN_W-1:0]           window;
  } cfg_t;

  typedef struct packed {
    ctl_t                ctl;
    logic                agree;
    logic [ADC_BITS-1:0] ax;
    logic [ADC_BITS-1:0] ay;
  } avg_t;

  typedef struct packed {
    ctl_t               ctl;
    logic               agree;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } coord_t;

endpackage

// File: hw/rtl/touch_sample_filter_and_press_tracker.sv
// Top level of the resistive touch trimmed-mean filter and press tracker.
//
//   Channel | Direction | Handshake             | Payload
//   in_     | input     | in_tvalid / in_tready | in_tdata: one ADC sample word
//   out_    | output    | out_tvalid/out_tready | out_tdata: one word per scan
//   cfg_    | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One sample word is taken every cycle while in_tready is high. A scan is one
// word on pen-up or 4 * SAMPLES_PER_READ words on pen-down; its result word is
// registered after passing through the statistics, division, averaging,
// calibration multiply and tracker stages.
// Reset is synchronous and needs no clearing pass; cfg_ready is always high.
// A stalled out_tready holds the result word; the stage registers keep
// filling and in_tready drops only once they are all occupied.
module touch_sample_filter_and_press_tracker #(
  parameter int SAMPLES_PER_READ = 5
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // in_tdata from bit 0: pen_down[0], sample[12:1], raw_mode[13],
  // clear_click[14], zero fill[15]
  input  logic [tsf_pkg::IN_DATA_W-1:0]     in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // out_tdata from bit 0: pressed[0], click_caught[1], reading_valid[2],
  // coord_x[18:3], coord_y[34:19], first_x[50:35], first_y[66:51], zero fill[71:67]
  output logic [tsf_pkg::OUT_DATA_W-1:0]    out_tdata,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tsf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tsf_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int SUM_W =
    $clog2(SAMPLES_PER_READ * ((1 << tsf_pkg::ADC_BITS) - 1) + 1);

  tsf_pkg::cfg_t          cfg_r;

  logic                   acc_valid;
  logic                   acc_ready;
  tsf_pkg::ctl_t          acc_ctl;
  logic [3:0][SUM_W-1:0]  acc_tsum;
  logic                   mean_valid;
  logic                   mean_ready;
  tsf_pkg::avg_t          mean_avg;
  logic                   cal_valid;
  logic                   cal_ready;
  tsf_pkg::coord_t        cal_coord;

  // Configuration registers; indexes past the list are ignored.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.x_scale  <= tsf_pkg::SCALE_RESET;
      cfg_r.y_scale  <= tsf_pkg::SCALE_RESET;
      cfg_r.x_offset <= tsf_pkg::OFFSET_RESET;
      cfg_r.y_offset <= tsf_pkg::OFFSET_RESET;
      cfg_r.window   <= tsf_pkg::WINDOW_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        tsf_pkg::CFG_X_SCALE:  cfg_r.x_scale  <= cfg_data[tsf_pkg::SCALE_W-1:0];
        tsf_pkg::CFG_Y_SCALE:  cfg_r.y_scale  <= cfg_data[tsf_pkg::SCALE_W-1:0];
        tsf_pkg::CFG_X_OFFSET: cfg_r.x_offset <= cfg_data[tsf_pkg::OFFSET_W-1:0];
        tsf_pkg::CFG_Y_OFFSET: cfg_r.y_offset <= cfg_data[tsf_pkg::OFFSET_W-1:0];
        tsf_pkg::CFG_WINDOW:   cfg_r.window   <= cfg_data[tsf_pkg::WIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Scan sequencing and group statistics.
  tsf_accum #(
    .SPR   (SAMPLES_PER_READ),
    .SUM_W (SUM_W)
  ) u_accum (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .pen_down    (in_tdata[0]),
    .sample      (in_tdata[12:1]),
    .raw_mode    (in_tdata[13]),
    .clear_click (in_tdata[14]),
    .out_valid   (acc_valid),
    .out_ready   (acc_ready),
    .out_ctl     (acc_ctl),
    .out_tsum    (acc_tsum)
  );

  // Trimmed means, agreement and averages.
  tsf_mean #(
    .SPR   (SAMPLES_PER_READ),
    .SUM_W (SUM_W)
  ) u_mean (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (acc_valid),
    .in_ready  (acc_ready),
    .in_ctl    (acc_ctl),
    .in_tsum   (acc_tsum),
    .window    (cfg_r.window),
    .out_valid (mean_valid),
    .out_ready (mean_ready),
    .out_avg   (mean_avg)
  );

  // Calibration.
  tsf_calib u_calib (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (mean_valid),
    .in_ready  (mean_ready),
    .in_avg    (mean_avg),
    .cfg       (cfg_r),
    .out_valid (cal_valid),
    .out_ready (cal_ready),
    .out_coord (cal_coord)
  );

  // Press tracking and result word.
  tsf_press u_press (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (cal_valid),
    .in_ready   (cal_ready),
    .in_coord   (cal_coord),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// File: hw/rtl/tsf_accum.sv
// Scan sequencing and per-group running sum, minimum and maximum of the samples.
module tsf_accum #(
  parameter int SPR   = 5,
  parameter int SUM_W = 15
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          pen_down,
  input  logic [tsf_pkg::ADC_BITS-1:0]  sample,
  input  logic                          raw_mode,
  input  logic                          clear_click,
  output logic                          out_valid,
  input  logic                          out_ready,
  output tsf_pkg::ctl_t                 out_ctl,
  output logic [3:0][SUM_W-1:0]         out_tsum
);

  localparam int POS_W = $clog2(SPR);
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(SPR - 1);

  logic [POS_W-1:0]                 pos_r;
  logic [1:0]                       grp_r;
  logic                             raw_r;
  logic [SUM_W-1:0]                 sum_r;
  logic [tsf_pkg::ADC_BITS-1:0]     lo_r;
  logic [tsf_pkg::ADC_BITS-1:0]     hi_r;
  logic [2:0][SUM_W-1:0]            tsum_r;
  logic                             out_valid_r;
  tsf_pkg::ctl_t                    out_ctl_r;
  logic [3:0][SUM_W-1:0]            out_tsum_r;

  logic                             accept;
  logic                             first;
  logic                             penup;
  logic                             grp_end;
  logic                             last_grp;
  logic                             raw_cur;
  logic [SUM_W-1:0]                 sum_nxt;
  logic [tsf_pkg::ADC_BITS-1:0]     lo_nxt;
  logic [tsf_pkg::ADC_BITS-1:0]     hi_nxt;
  logic [SUM_W-1:0]                 trim;
  tsf_pkg::ctl_t                    ctl_nxt;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  // Decode where the word sits within the scan.
  always_comb begin
    first    = (pos_r == '0) && (grp_r == 2'd0);
    penup    = first && !pen_down;
    grp_end  = !penup && (pos_r == LAST_POS);
    last_grp = grp_end && (grp_r == 2'd3);
    raw_cur  = first ? raw_mode : raw_r;
  end

  // Running statistics of the current group and its trimmed sum.
  always_comb begin
    if (pos_r == '0) begin
      sum_nxt = SUM_W'(sample);
      lo_nxt  = sample;
      hi_nxt  = sample;
    end else begin
      sum_nxt = sum_r + SUM_W'(sample);
      lo_nxt  = (sample < lo_r) ? sample : lo_r;
      hi_nxt  = (sample > hi_r) ? sample : hi_r;
    end
    trim = sum_nxt - SUM_W'(lo_nxt) - SUM_W'(hi_nxt);
  end

  // Control word for the later stages.
  always_comb begin
    ctl_nxt.clear = clear_click;
    ctl_nxt.raw   = raw_cur;
    if (penup) begin
      ctl_nxt.op = tsf_pkg::OP_PENUP;
    end else if (last_grp) begin
      ctl_nxt.op = tsf_pkg::OP_FINAL;
    end else begin
      ctl_nxt.op = tsf_pkg::OP_NONE;
    end
  end

  // Scan position and group statistics.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      grp_r <= 2'd0;
      raw_r <= 1'b0;
    end else if (accept) begin
      if (first) begin
        raw_r <= raw_mode;
      end
      if (!penup) begin
        if (grp_end) begin
          pos_r <= '0;
          grp_r <= grp_r + 2'd1;
        end else begin
          pos_r <= pos_r + POS_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !penup) begin
      sum_r <= sum_nxt;
      lo_r  <= lo_nxt;
      hi_r  <= hi_nxt;
      if (grp_end) begin
        case (grp_r)
          2'd0:    tsum_r[0] <= trim;
          2'd1:    tsum_r[1] <= trim;
          2'd2:    tsum_r[2] <= trim;
          default: ;
        endcase
      end
    end
  end

  // Output register; words that change nothing downstream are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_ready) begin
      out_valid_r <= accept && ((ctl_nxt.op != tsf_pkg::OP_NONE) || clear_click);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_ctl_r  <= ctl_nxt;
      out_tsum_r <= {trim, tsum_r[2], tsum_r[1], tsum_r[0]};
    end
  end

  assign out_valid = out_valid_r;
  assign out_ctl   = out_ctl_r;
  assign out_tsum  = out_tsum_r;

endmodule

// File: hw/rtl/tsf_mean.sv
// Trimmed means by constant reciprocal, then the agreement check and pair averages.
module tsf_mean #(
  parameter int SPR   = 5,
  parameter int SUM_W = 15
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  tsf_pkg::ctl_t          in_ctl,
  input  logic [3:0][SUM_W-1:0]  in_tsum,
  input  logic [tsf_pkg::WIN_W-1:0] window,
  output logic                   out_valid,
  input  logic                   out_ready,
  output tsf_pkg::avg_t          out_avg
);

  localparam int DIV = SPR - 2;
  localparam logic [SUM_W:0] RECIP = (SUM_W + 1)'((2 ** SUM_W) / DIV);
  localparam logic [SUM_W-1:0] DIV_V = SUM_W'(DIV);

  logic                                  va_r;
  tsf_pkg::ctl_t                         ctl_a_r;
  logic [3:0][tsf_pkg::ADC_BITS-1:0]     q_a_r;
  logic                                  vb_r;
  tsf_pkg::avg_t                         avg_r;

  logic                                  rdy_a;
  logic                                  rdy_b;
  logic [3:0][tsf_pkg::ADC_BITS-1:0]     q_nxt;
  logic [2*SUM_W:0]                      prod [4];
  logic [SUM_W-1:0]                      q0 [4];
  logic [SUM_W-1:0]                      rem [4];
  logic [SUM_W-1:0]                      qc [4];
  logic [tsf_pkg::ADC_BITS-1:0]          dx;
  logic [tsf_pkg::ADC_BITS-1:0]          dy;
  logic [tsf_pkg::ADC_BITS:0]            sx;
  logic [tsf_pkg::ADC_BITS:0]            sy;
  tsf_pkg::avg_t                         avg_nxt;

  assign rdy_b    = !vb_r || out_ready;
  assign rdy_a    = !va_r || rdy_b;
  assign in_ready = rdy_a;

  // Division of each trimmed sum by the group size less two: the reciprocal
  // estimate is exact or one low, and one compare fixes it.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      prod[i]  = (2 * SUM_W + 1)'(in_tsum[i]) * (2 * SUM_W + 1)'(RECIP);
      q0[i]    = prod[i][2*SUM_W-1:SUM_W];
      rem[i]   = in_tsum[i] - SUM_W'(q0[i] * DIV_V);
      qc[i]    = (rem[i] >= DIV_V) ? q0[i] + SUM_W'(1) : q0[i];
      q_nxt[i] = qc[i][tsf_pkg::ADC_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (rdy_a) begin
      va_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_a && in_valid) begin
      ctl_a_r <= in_ctl;
      q_a_r   <= q_nxt;
    end
  end

  // Agreement of the two X and the two Y readings, and their averages.
  // Lane order is first X, first Y, second X, second Y.
  always_comb begin
    dx = (q_a_r[0] > q_a_r[2]) ? q_a_r[0] - q_a_r[2] : q_a_r[2] - q_a_r[0];
    dy = (q_a_r[1] > q_a_r[3]) ? q_a_r[1] - q_a_r[3] : q_a_r[3] - q_a_r[1];
    sx = {1'b0, q_a_r[0]} + {1'b0, q_a_r[2]};
    sy = {1'b0, q_a_r[1]} + {1'b0, q_a_r[3]};
    avg_nxt.ctl   = ctl_a_r;
    avg_nxt.agree = (dx < window) && (dy < window);
    avg_nxt.ax    = sx[tsf_pkg::ADC_BITS:1];
    avg_nxt.ay    = sy[tsf_pkg::ADC_BITS:1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else if (rdy_b) begin
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_b && va_r) begin
      avg_r <= avg_nxt;
    end
  end

  assign out_valid = vb_r;
  assign out_avg   = avg_r;

endmodule

// File: hw/rtl/tsf_calib.sv
// Calibration: registered scale products, then offset add with truncation toward zero.
module tsf_calib (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  tsf_pkg::avg_t  in_avg,
  input  tsf_pkg::cfg_t  cfg,
  output logic           out_valid,
  input  logic           out_ready,
  output tsf_pkg::coord_t out_coord
);

  localparam int PROD_W = tsf_pkg::SCALE_W + tsf_pkg::ADC_BITS + 1;
  localparam int TOT_W  = PROD_W + 1;
  localparam int FRAC_W = 16;
  localparam int OFF_EXT_W = TOT_W - tsf_pkg::OFFSET_W - FRAC_W;

  logic                       v_r;
  tsf_pkg::avg_t              avg_r;
  logic signed [PROD_W-1:0]   prod_x_r;
  logic signed [PROD_W-1:0]   prod_y_r;

  logic signed [PROD_W-1:0]   prod_x_nxt;
  logic signed [PROD_W-1:0]   prod_y_nxt;
  logic [TOT_W-1:0]           tot_x;
  logic [TOT_W-1:0]           tot_y;
  logic [tsf_pkg::COORD_W-1:0] cal_x;
  logic [tsf_pkg::COORD_W-1:0] cal_y;

  assign in_ready = !v_r || out_ready;

  // Products of the scale factors with the averaged readings.
  always_comb begin
    prod_x_nxt = PROD_W'(cfg.x_scale) * PROD_W'($signed({1'b0, in_avg.ax}));
    prod_y_nxt = PROD_W'(cfg.y_scale) * PROD_W'($signed({1'b0, in_avg.ay}));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      avg_r    <= in_avg;
      prod_x_r <= prod_x_nxt;
      prod_y_r <= prod_y_nxt;
    end
  end

  // Add the offset in the integer part; a negative total with a fraction
  // rounds up by one so the quotient truncates toward zero.
  always_comb begin
    tot_x = {prod_x_r[PROD_W-1], prod_x_r} +
            {{OFF_EXT_W{cfg.x_offset[tsf_pkg::OFFSET_W-1]}}, cfg.x_offset, {FRAC_W{1'b0}}};
    tot_y = {prod_y_r[PROD_W-1], prod_y_r} +
            {{OFF_EXT_W{cfg.y_offset[tsf_pkg::OFFSET_W-1]}}, cfg.y_offset, {FRAC_W{1'b0}}};
    cal_x = tot_x[FRAC_W+tsf_pkg::COORD_W-1:FRAC_W] +
            tsf_pkg::COORD_W'(tot_x[TOT_W-1] && (tot_x[FRAC_W-1:0] != '0));
    cal_y = tot_y[FRAC_W+tsf_pkg::COORD_W-1:FRAC_W] +
            tsf_pkg::COORD_W'(tot_y[TOT_W-1] && (tot_y[FRAC_W-1:0] != '0));
  end

  // Raw scans bypass the calibration.
  always_comb begin
    out_coord.ctl   = avg_r.ctl;
    out_coord.agree = avg_r.agree;
    if (avg_r.ctl.raw) begin
      out_coord.x = tsf_pkg::COORD_W'(avg_r.ax);
      out_coord.y = tsf_pkg::COORD_W'(avg_r.ay);
    end else begin
      out_coord.x = cal_x;
      out_coord.y = cal_y;
    end
  end

  assign out_valid = v_r;

endmodule

// File: hw/rtl/tsf_press.sv
// Press tracker state, coordinate registers and the result word register.
module tsf_press (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  tsf_pkg::coord_t                 in_coord,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [tsf_pkg::OUT_DATA_W-1:0]  out_tdata
);

  logic                            pressed_r;
  logic                            caught_r;
  logic [tsf_pkg::COORD_W-1:0]     cur_x_r;
  logic [tsf_pkg::COORD_W-1:0]     cur_y_r;
  logic [tsf_pkg::COORD_W-1:0]     pr_x_r;
  logic [tsf_pkg::COORD_W-1:0]     pr_y_r;
  logic                            out_valid_r;
  logic [tsf_pkg::OUT_DATA_W-1:0]  out_data_r;

  logic                            emits;
  logic                            take;
  logic                            pressed_nxt;
  logic                            caught_nxt;
  logic                            rd_valid;
  logic [tsf_pkg::COORD_W-1:0]     cur_x_nxt;
  logic [tsf_pkg::COORD_W-1:0]     cur_y_nxt;
  logic [tsf_pkg::COORD_W-1:0]     pr_x_nxt;
  logic [tsf_pkg::COORD_W-1:0]     pr_y_nxt;

  // A word that only clears the click flag needs no output slot.
  assign emits    = in_coord.ctl.op != tsf_pkg::OP_NONE;
  assign in_ready = !emits || !out_valid_r || out_tready;
  assign take     = in_valid && in_ready;

  // Pressed and click state update for one word.
  always_comb begin
    pressed_nxt = pressed_r;
    caught_nxt  = caught_r && !in_coord.ctl.clear;
    cur_x_nxt   = cur_x_r;
    cur_y_nxt   = cur_y_r;
    pr_x_nxt    = pr_x_r;
    pr_y_nxt    = pr_y_r;
    rd_valid    = 1'b0;
    case (in_coord.ctl.op)
      tsf_pkg::OP_PENUP: begin
        if (pressed_r) begin
          pressed_nxt = 1'b0;
        end else begin
          pr_x_nxt  = '0;
          pr_y_nxt  = '0;
          cur_x_nxt = tsf_pkg::IDLE_COORD;
          cur_y_nxt = tsf_pkg::IDLE_COORD;
        end
      end
      tsf_pkg::OP_FINAL: begin
        rd_valid = in_coord.agree;
        if (in_coord.agree) begin
          cur_x_nxt = in_coord.x;
          cur_y_nxt = in_coord.y;
        end
        if (!pressed_r) begin
          pressed_nxt = 1'b1;
          caught_nxt  = 1'b1;
          pr_x_nxt    = cur_x_nxt;
          pr_y_nxt    = cur_y_nxt;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pressed_r <= 1'b0;
      caught_r  <= 1'b0;
      cur_x_r   <= '0;
      cur_y_r   <= '0;
      pr_x_r    <= '0;
      pr_y_r    <= '0;
    end else if (take) begin
      pressed_r <= pressed_nxt;
      caught_r  <= caught_nxt;
      cur_x_r   <= cur_x_nxt;
      cur_y_r   <= cur_y_nxt;
      pr_x_r    <= pr_x_nxt;
      pr_y_r    <= pr_y_nxt;
    end
  end

  // Result word register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take && emits) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && emits) begin
      out_data_r <= {5'b0, pr_y_nxt, pr_x_nxt, cur_y_nxt, cur_x_nxt,
                     rd_valid, caught_nxt, pressed_nxt};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// File: sim/tb_top.sv
// Self-checking testbench for the touch sample filter and press tracker.
`timescale 1ns / 1ps

module tb_top;

  localparam int GROUP_LEN     = 5;
  localparam int SCAN_LEN      = 4 * GROUP_LEN;
  localparam int SETTLE_CYCLES = 12;
  localparam int HOLD_CYCLES   = 300;
  localparam int PHASE_WORDS   = 160;

  // One input word; fields listed from the top bit down.
  typedef struct packed {
    logic                         clear_click;
    logic                         raw_mode;
    logic [tsf_pkg::ADC_BITS-1:0] sample;
    logic                         pen_down;
  } sample_word_t;

  // One scan report; fields listed from the top bit down.
  typedef struct packed {
    logic [tsf_pkg::COORD_W-1:0] first_y;
    logic [tsf_pkg::COORD_W-1:0] first_x;
    logic [tsf_pkg::COORD_W-1:0] coord_y;
    logic [tsf_pkg::COORD_W-1:0] coord_x;
    logic                        reading_valid;
    logic                        click_caught;
    logic                        pressed;
  } scan_report_t;

  typedef logic [tsf_pkg::ADC_BITS-1:0] scan_samples_t [SCAN_LEN];

  // Predicts the report of every scan and checks the reports that come out.
  class press_report_model;
    logic signed [tsf_pkg::SCALE_W-1:0]  x_scale, y_scale;
    logic signed [tsf_pkg::OFFSET_W-1:0] x_offset, y_offset;
    logic [tsf_pkg::WIN_W-1:0]           window;
    logic [tsf_pkg::ADC_BITS-1:0]        group_buf [GROUP_LEN];
    int unsigned                         word_count;
    bit                                  scan_raw, pressed, caught;
    logic [tsf_pkg::ADC_BITS-1:0]        x_first, y_first, x_second;
    logic [tsf_pkg::COORD_W-1:0]         cur_x, cur_y, press_x, press_y;
    scan_report_t                        pending_reports[$];
    int                                  errors, words_seen, reports_seen, agreed_reports;

    function new();
      x_scale = tsf_pkg::SCALE_RESET;
      y_scale = tsf_pkg::SCALE_RESET;
      x_offset = tsf_pkg::OFFSET_RESET;
      y_offset = tsf_pkg::OFFSET_RESET;
      window = tsf_pkg::WINDOW_RESET;
      word_count = 0;
      scan_raw = 0;
      pressed = 0;
      caught = 0;
      x_first = '0;
      y_first = '0;
      x_second = '0;
      cur_x = '0;
      cur_y = '0;
      press_x = '0;
      press_y = '0;
      errors = 0;
      words_seen = 0;
      reports_seen = 0;
      agreed_reports = 0;
    endfunction

    function int pending();
      return pending_reports.size();
    endfunction

    function void apply_register(logic [tsf_pkg::CFG_IDX_W-1:0] idx,
                                 logic [tsf_pkg::CFG_DATA_W-1:0] value);
      case (idx)
        tsf_pkg::CFG_X_SCALE:  x_scale = value;
        tsf_pkg::CFG_Y_SCALE:  y_scale = value;
        tsf_pkg::CFG_X_OFFSET: x_offset = value[tsf_pkg::OFFSET_W-1:0];
        tsf_pkg::CFG_Y_OFFSET: y_offset = value[tsf_pkg::OFFSET_W-1:0];
        tsf_pkg::CFG_WINDOW:   window = value[tsf_pkg::WIN_W-1:0];
        default: ;
      endcase
    endfunction

    // Mean of the group with its lowest and highest sample left out.
    function logic [tsf_pkg::ADC_BITS-1:0] trimmed_mean();
      int unsigned total, lo, hi;
      total = 0;
      lo = 32'(group_buf[0]);
      hi = 32'(group_buf[0]);
      for (int i = 0; i < GROUP_LEN; i++) begin
        total += 32'(group_buf[i]);
        if (group_buf[i] < lo) lo = 32'(group_buf[i]);
        if (group_buf[i] > hi) hi = 32'(group_buf[i]);
      end
      return tsf_pkg::ADC_BITS'((total - lo - hi) / (GROUP_LEN - 2));
    endfunction

    function bit readings_agree(logic [tsf_pkg::ADC_BITS-1:0] a,
                                logic [tsf_pkg::ADC_BITS-1:0] b);
      logic [tsf_pkg::ADC_BITS-1:0] d;
      d = (a > b) ? a - b : b - a;
      return d < window;
    endfunction

    // Q4.16 scale, then offset; quotient truncated toward zero, low 16 bits kept.
    function logic [tsf_pkg::COORD_W-1:0] calibrate(
        logic [tsf_pkg::ADC_BITS-1:0] v,
        logic signed [tsf_pkg::SCALE_W-1:0] scale,
        logic signed [tsf_pkg::OFFSET_W-1:0] offset);
      longint total, q;
      total = longint'(scale) * longint'(v) + longint'(offset) * 65536;
      q = total / 65536;
      return q[tsf_pkg::COORD_W-1:0];
    endfunction

    function void push_report(bit ok);
      scan_report_t r;
      r.pressed = pressed;
      r.click_caught = caught;
      r.reading_valid = ok;
      r.coord_x = cur_x;
      r.coord_y = cur_y;
      r.first_x = press_x;
      r.first_y = press_y;
      pending_reports.push_back(r);
      if (ok) agreed_reports++;
    endfunction

    // Called for every accepted input word.
    function void take_sample(logic [tsf_pkg::IN_DATA_W-1:0] word);
      sample_word_t                 w;
      int unsigned                  grp, pos;
      logic [tsf_pkg::ADC_BITS-1:0] y_second, ax, ay;
      bit                           ok;
      w = word[$bits(sample_word_t)-1:0];
      words_seen++;
      if (w.clear_click) caught = 0;
      if (word_count == 0) begin
        scan_raw = w.raw_mode;
        if (!w.pen_down) begin
          if (pressed) begin
            pressed = 0;
          end else begin
            press_x = '0;
            press_y = '0;
            cur_x = tsf_pkg::IDLE_COORD;
            cur_y = tsf_pkg::IDLE_COORD;
          end
          push_report(0);
          return;
        end
      end
      grp = word_count / GROUP_LEN;
      pos = word_count % GROUP_LEN;
      group_buf[pos] = w.sample;
      word_count++;
      if (pos != GROUP_LEN - 1) return;
      case (grp)
        0: x_first = trimmed_mean();
        1: y_first = trimmed_mean();
        2: x_second = trimmed_mean();
        default: begin
          y_second = trimmed_mean();
          ok = readings_agree(x_first, x_second) && readings_agree(y_first, y_second);
          word_count = 0;
          if (ok) begin
            ax = ({1'b0, x_first} + {1'b0, x_second}) >> 1;
            ay = ({1'b0, y_first} + {1'b0, y_second}) >> 1;
            if (scan_raw) begin
              cur_x = 16'(ax);
              cur_y = 16'(ay);
            end else begin
              cur_x = calibrate(ax, x_scale, x_offset);
              cur_y = calibrate(ay, y_scale, y_offset);
            end
          end
          // A finished pen-down scan starts a press if none is active.
          if (!pressed) begin
            pressed = 1;
            caught = 1;
            press_x = cur_x;
            press_y = cur_y;
          end
          push_report(ok);
        end
      endcase
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    // Called for every accepted result word.
    function void check_report(logic [tsf_pkg::OUT_DATA_W-1:0] word);
      scan_report_t got, want;
      got = word[$bits(scan_report_t)-1:0];
      reports_seen++;
      if (pending_reports.size() == 0) begin
        errors++;
        $display("%0t: unexpected report, expected none, actual %h", $time, word);
        return;
      end
      want = pending_reports.pop_front();
      compare_field("pressed", 32'(want.pressed), 32'(got.pressed));
      compare_field("click_caught", 32'(want.click_caught), 32'(got.click_caught));
      compare_field("reading_valid", 32'(want.reading_valid), 32'(got.reading_valid));
      compare_field("coord_x", 32'(want.coord_x), 32'(got.coord_x));
      compare_field("coord_y", 32'(want.coord_y), 32'(got.coord_y));
      compare_field("first_x", 32'(want.first_x), 32'(got.first_x));
      compare_field("first_y", 32'(want.first_y), 32'(got.first_y));
      compare_field("zero fill", 0,
                    32'(word[tsf_pkg::OUT_DATA_W-1:$bits(scan_report_t)]));
    endfunction
  endclass

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_tvalid = 1'b0;
  logic                           in_tready;
  logic [tsf_pkg::IN_DATA_W-1:0]  in_tdata = '0;
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [tsf_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [tsf_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [tsf_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  press_report_model press_model;
  bit steady = 0;
  bit hold_request = 0;
  bit hold_active = 0;
  int settings_used = 1;

  touch_sample_filter_and_press_tracker #(
    .SAMPLES_PER_READ(GROUP_LEN)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Mostly short idle gaps, a few long ones.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Watch every handshake at the rising edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) press_model.apply_register(cfg_index, cfg_data);
      if (in_tvalid && in_tready) press_model.take_sample(in_tdata);
      if (out_tvalid && out_tready) press_model.check_report(out_tdata);
    end
  end

  // Result side: random ready pattern, steady ready, or one long hold-off.
  initial begin : receiver
    int stretch;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_tready <= 1'b0;
        hold_active = 1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_active = 0;
        hold_request = 0;
      end else if (steady) begin
        out_tready <= 1'b1;
      end else if ($urandom_range(0, 1)) begin
        out_tready <= 1'b1;
        stretch = $urandom_range(1, 12);
        repeat (stretch - 1) @(negedge clk);
      end else begin
        out_tready <= 1'b0;
        stretch = gap_len() + 1;
        repeat (stretch - 1) @(negedge clk);
      end
    end
  end

  // Offer one word after a random gap (none while steady) and wait until it is taken.
  task automatic send_word(input sample_word_t w);
    int gap;
    gap = steady ? 0 : gap_len();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      in_tdata <= tsf_pkg::IN_DATA_W'($urandom);
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {1'b0, w};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_pen_up(input bit clear, input bit raw,
                             input logic [tsf_pkg::ADC_BITS-1:0] level);
    sample_word_t w;
    w.pen_down = 1'b0;
    w.sample = level;
    w.raw_mode = raw;
    w.clear_click = clear;
    send_word(w);
  endtask

  // A pen-down scan; pen and mode bits after the first word are noise.
  task automatic send_scan(input bit raw, input scan_samples_t s);
    sample_word_t w;
    for (int i = 0; i < SCAN_LEN; i++) begin
      w.pen_down = (i == 0) ? 1'b1 : 1'($urandom_range(0, 1));
      w.raw_mode = (i == 0) ? raw : 1'($urandom_range(0, 1));
      w.sample = s[i];
      w.clear_click = ($urandom_range(0, 99) < 8);
      send_word(w);
    end
  endtask

  function automatic int pick_level();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 0;
    if (r == 1) return (1 << tsf_pkg::ADC_BITS) - 1;
    return $urandom_range(0, (1 << tsf_pkg::ADC_BITS) - 1);
  endfunction

  // Jittered groups around chosen levels, with outliers; some scans are noise.
  task automatic make_samples(output scan_samples_t s);
    int kind, noise, outlier_pct, v;
    int level [4];
    kind = $urandom_range(0, 9);
    noise = $urandom_range(0, 4);
    outlier_pct = $urandom_range(0, 25);
    level[0] = pick_level();
    level[1] = pick_level();
    if (kind < 6) begin
      level[2] = level[0] + int'($urandom_range(0, 80)) - 40;
      level[3] = level[1] + int'($urandom_range(0, 80)) - 40;
    end else begin
      level[2] = pick_level();
      level[3] = pick_level();
    end
    for (int g = 0; g < 4; g++) begin
      for (int i = 0; i < GROUP_LEN; i++) begin
        v = level[g] + int'($urandom_range(0, 2 * noise)) - noise;
        if (kind >= 8 || $urandom_range(0, 99) < outlier_pct)
          v = $urandom_range(0, (1 << tsf_pkg::ADC_BITS) - 1);
        if (v < 0) v = 0;
        if (v > (1 << tsf_pkg::ADC_BITS) - 1) v = (1 << tsf_pkg::ADC_BITS) - 1;
        s[g * GROUP_LEN + i] = v[tsf_pkg::ADC_BITS-1:0];
      end
    end
  endtask

  // Stop offering and wait until every report is in and the pipeline is quiet.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (press_model.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [tsf_pkg::CFG_IDX_W-1:0] idx,
                           input logic [tsf_pkg::CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Register values are given as integers and cut to their field widths here.
  task automatic program_regs(input int xs, input int ys, input int xo, input int yo,
                              input int win);
    cfg_write(tsf_pkg::CFG_X_SCALE, xs[tsf_pkg::SCALE_W-1:0]);
    cfg_write(tsf_pkg::CFG_Y_SCALE, ys[tsf_pkg::SCALE_W-1:0]);
    cfg_write(tsf_pkg::CFG_X_OFFSET,
              {{(tsf_pkg::CFG_DATA_W - tsf_pkg::OFFSET_W){xo[tsf_pkg::OFFSET_W-1]}},
               xo[tsf_pkg::OFFSET_W-1:0]});
    cfg_write(tsf_pkg::CFG_Y_OFFSET,
              {{(tsf_pkg::CFG_DATA_W - tsf_pkg::OFFSET_W){yo[tsf_pkg::OFFSET_W-1]}},
               yo[tsf_pkg::OFFSET_W-1:0]});
    cfg_write(tsf_pkg::CFG_WINDOW,
              {{(tsf_pkg::CFG_DATA_W - tsf_pkg::WIN_W){1'b0}}, win[tsf_pkg::WIN_W-1:0]});
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // Random mix of pen-up words and pen-down scans, then drain.
  task automatic run_phase(input int n_words, input bit no_gaps);
    int sent;
    scan_samples_t s;
    steady = no_gaps;
    sent = 0;
    while (sent < n_words) begin
      if ($urandom_range(0, 99) < 18) begin
        send_pen_up($urandom_range(0, 99) < 15, 1'($urandom_range(0, 1)),
                    tsf_pkg::ADC_BITS'($urandom));
        sent += 1;
      end else begin
        make_samples(s);
        send_scan(1'($urandom_range(0, 1)), s);
        sent += SCAN_LEN;
      end
      if ($urandom_range(0, 99) < 4) wait_idle();
    end
    wait_idle();
  endtask

  initial begin
    #6_000_000;
    $display("FAIL touch_sample_filter_and_press_tracker");
    $finish;
  end

  initial begin : stimulus
    scan_samples_t s;
    press_model = new();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: two pen-ups while idle, a full-scale scan with outliers trimmed,
    // pen-up while pressed with a click clear, then pen-up while idle again.
    send_pen_up(1'b1, 1'b0, '0);
    send_pen_up(1'b0, 1'b1, '1);
    for (int i = 0; i < SCAN_LEN; i++) begin
      if ((i / GROUP_LEN) % 2 == 0)
        s[i] = (i % GROUP_LEN == 1) ? '0 : '1;
      else
        s[i] = (i % GROUP_LEN == 1) ? '1 : '0;
    end
    send_scan(1'b0, s);
    send_pen_up(1'b1, 1'b0, '1);
    send_pen_up(1'b0, 1'b0, '0);
    wait_idle();

    // Output held off while the input keeps offering words.
    hold_request = 1;
    wait (hold_active);
    steady = 1;
    for (int i = 0; i < 40; i++)
      send_pen_up(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  tsf_pkg::ADC_BITS'($urandom));
    make_samples(s);
    send_scan(1'b1, s);
    wait_idle();

    // Random phases over a range of calibration and window settings.
    run_phase(PHASE_WORDS, 1'b0);
    program_regs(65536, 65536, 0, 0, 4095);
    run_phase(PHASE_WORDS, 1'b1);
    program_regs(-524288, 524287, -32768, 32767, 60);
    run_phase(PHASE_WORDS, 1'b0);
    program_regs($urandom, $urandom, $urandom, $urandom, 0);
    run_phase(PHASE_WORDS, 1'b0);
    program_regs(0, 0, $urandom, $urandom, 1);
    run_phase(PHASE_WORDS, 1'b0);
    program_regs($urandom, $urandom, $urandom, $urandom, $urandom_range(20, 200));
    run_phase(PHASE_WORDS, 1'b0);
    program_regs(524287, -524288, 32767, -32768, 4095);
    run_phase(PHASE_WORDS, 1'b0);
    program_regs($urandom, $urandom, $urandom, $urandom, $urandom_range(0, 4095));
    run_phase(PHASE_WORDS, 1'b1);

    $display("Run covered %0d sample words and %0d scan reports, %0d of them with agreeing",
             press_model.words_seen, press_model.reports_seen, press_model.agreed_reports);
    $display("readings, across %0d register settings and one long output hold-off.",
             settings_used);
    if (press_model.errors == 0) begin
      $display("PASS touch_sample_filter_and_press_tracker");
    end else begin
      $display("FAIL touch_sample_filter_and_press_tracker");
    end
    $finish;
  end

endmodule
